/* rtl/hkm_pkg.sv */
// ============================================================================
// hkm_pkg
// Shared types, codes and defaults of the heartbeat keepalive monitor.
// ============================================================================
package hkm_pkg;

    localparam int MAX_PEERS_DEF = 16;

    localparam logic [15:0] INTERVAL_RST = 16'd1000;
    localparam logic [3:0]  RETRIES_RST  = 4'd5;
    localparam logic [31:0] TIMEOUT_RST  = 32'd10000;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [4:0]  RETRY_SAT = 5'd31;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_RETRIES  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

    // Input actions.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_REPLY = 2'd1;
    localparam logic [1:0] ACT_ADD   = 2'd2;

    // Result events.
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_SEND       = 3'd1;
    localparam logic [2:0] EV_TIMEOUT    = 3'd2;
    localparam logic [2:0] EV_REPLY_OK   = 3'd3;
    localparam logic [2:0] EV_REPLY_UNEX = 3'd4;
    localparam logic [2:0] EV_UNKNOWN    = 3'd5;
    localparam logic [2:0] EV_ADDED      = 3'd6;
    localparam logic [2:0] EV_REFUSED    = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] last_heard;
        logic [31:0] probe_time;
        logic        waiting;
        logic [4:0]  retries;
    } slot_t;

    typedef struct packed {
        logic [15:0] interval;
        logic [3:0]  retries;
        logic [31:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] id;
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] stamp;
        logic [31:0] latency;
        logic        full;
        logic        last;
    } result_t;

endpackage

/* rtl/hkm_slot_ram.sv */
// ============================================================================
// hkm_slot_ram
// Slot table memory: one write port, one read port, registered read data.
// ============================================================================
module hkm_slot_ram #(
    parameter int DEPTH = hkm_pkg::MAX_PEERS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output hkm_pkg::slot_t       rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  hkm_pkg::slot_t       wr_data
);

    hkm_pkg::slot_t mem [DEPTH];
    hkm_pkg::slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/hkm_engine.sv */
// ============================================================================
// hkm_engine
// Sequencer that walks the slot memory for ticks, replies and adds.
// ============================================================================
module hkm_engine #(
    parameter int MAX_PEERS = hkm_pkg::MAX_PEERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        action,
    input  logic [31:0]       peer_address,
    input  logic [15:0]       peer_port,
    input  logic [15:0]       tick_ms,
    input  hkm_pkg::cfg_t     cfg,
    output logic              busy,
    output logic              res_valid,
    output hkm_pkg::result_t  res
);

    localparam int IDXW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CW   = $clog2(MAX_PEERS + 1);
    localparam logic [CW-1:0] CNT_END = CW'(MAX_PEERS);

    hkm_pkg::state_t  state_reg, state_next;
    logic [1:0]       action_reg, action_next;
    logic [31:0]      addr_reg, addr_next;
    logic [15:0]      port_reg, port_next;
    logic [31:0]      time_reg, time_next;
    logic [31:0]      next_id_reg, next_id_next;
    logic [MAX_PEERS-1:0] valid_reg, valid_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             ev_valid_reg, ev_valid_next;
    logic [IDXW-1:0]  ev_idx_reg, ev_idx_next;
    logic             found_reg, found_next;
    logic [IDXW-1:0]  found_idx_reg, found_idx_next;
    hkm_pkg::slot_t   found_reg_data, found_data_next;
    hkm_pkg::result_t pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    hkm_pkg::result_t res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    logic             rd_en;
    logic [IDXW-1:0]  rd_addr;
    hkm_pkg::slot_t   rd_data;
    logic             wr_en;
    logic [IDXW-1:0]  wr_addr;
    hkm_pkg::slot_t   wr_data;

    logic [31:0]      elapsed;
    logic [21:0]      sched;
    logic             slot_live;
    logic             key_hit;
    logic             free_any;
    logic [IDXW-1:0]  free_idx;
    hkm_pkg::result_t ev_res;
    logic             ev_fire;

    hkm_slot_ram #(
        .DEPTH (MAX_PEERS),
        .AW    (IDXW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Lowest free slot.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = MAX_PEERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDXW'(i);
            end
        end
    end

    assign slot_live = ev_valid_reg && valid_reg[ev_idx_reg];
    assign elapsed   = time_reg - rd_data.last_heard;
    assign sched     = 22'(cfg.interval) * 22'({1'b0, rd_data.retries} + 6'd1);
    assign key_hit   = slot_live && (rd_data.address == addr_reg)
                       && (rd_data.port == port_reg);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        addr_next       = addr_reg;
        port_next       = port_reg;
        time_next       = time_reg;
        next_id_next    = next_id_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        ev_valid_next   = 1'b0;
        ev_idx_next     = ev_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_data_next = found_reg_data;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        res_next        = res_reg;
        res_valid_next  = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = cnt_reg[IDXW-1:0];
        wr_en           = 1'b0;
        wr_addr         = ev_idx_reg;
        wr_data         = rd_data;
        ev_fire         = 1'b0;
        ev_res          = '0;
        ev_res.id       = hkm_pkg::ALL_ONES;

        // Slot scan: one read issued per cycle, evaluated the cycle after.
        if ((state_reg == hkm_pkg::ST_TICK || state_reg == hkm_pkg::ST_SEARCH)
            && cnt_reg != CNT_END)
        begin
            rd_en         = 1'b1;
            cnt_next      = cnt_reg + CW'(1);
            ev_valid_next = 1'b1;
            ev_idx_next   = cnt_reg[IDXW-1:0];
        end

        case (state_reg)
            hkm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    action_next     = action;
                    addr_next       = peer_address;
                    port_next       = peer_port;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    if (action == hkm_pkg::ACT_TICK)
                    begin
                        time_next  = time_reg + 32'(tick_ms);
                        state_next = hkm_pkg::ST_TICK;
                    end
                    else if (action == hkm_pkg::ACT_REPLY || action == hkm_pkg::ACT_ADD)
                    begin
                        state_next = hkm_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        state_next = hkm_pkg::ST_FINISH;
                    end
                end
            end

            hkm_pkg::ST_TICK:
            begin
                if (slot_live && elapsed >= 32'(cfg.interval))
                begin
                    ev_res.id      = rd_data.id;
                    ev_res.address = rd_data.address;
                    ev_res.port    = rd_data.port;
                    if (elapsed >= cfg.timeout || rd_data.retries > {1'b0, cfg.retries})
                    begin
                        ev_fire               = 1'b1;
                        ev_res.ev             = hkm_pkg::EV_TIMEOUT;
                        valid_next[ev_idx_reg] = 1'b0;
                    end
                    else if (!rd_data.waiting || elapsed >= 32'(sched))
                    begin
                        ev_fire        = 1'b1;
                        ev_res.ev      = hkm_pkg::EV_SEND;
                        ev_res.stamp   = time_reg;
                        wr_en          = 1'b1;
                        wr_data.waiting = 1'b1;
                        if (rd_data.retries == 5'd0)
                        begin
                            wr_data.probe_time = time_reg;
                        end
                        if (rd_data.retries != hkm_pkg::RETRY_SAT)
                        begin
                            wr_data.retries = rd_data.retries + 5'd1;
                        end
                    end
                end

                // A result is held back until it is known whether it is the last.
                if (ev_fire)
                begin
                    if (pend_valid_reg)
                    begin
                        res_next       = pend_reg;
                        res_valid_next = 1'b1;
                    end
                    pend_next       = ev_res;
                    pend_valid_next = 1'b1;
                end
                else if (!ev_valid_reg && cnt_reg == CNT_END)
                begin
                    res_valid_next = 1'b1;
                    res_next       = pend_valid_reg ? pend_reg : ev_res;
                    res_next.last  = 1'b1;
                    state_next     = hkm_pkg::ST_IDLE;
                end
            end

            hkm_pkg::ST_SEARCH:
            begin
                if (key_hit)
                begin
                    found_next      = 1'b1;
                    found_idx_next  = ev_idx_reg;
                    found_data_next = rd_data;
                    state_next      = hkm_pkg::ST_FINISH;
                end
                else if (!ev_valid_reg && cnt_reg == CNT_END)
                begin
                    state_next = hkm_pkg::ST_FINISH;
                end
            end

            hkm_pkg::ST_FINISH:
            begin
                res_valid_next = 1'b1;
                res_next       = '0;
                res_next.id    = hkm_pkg::ALL_ONES;
                res_next.last  = 1'b1;
                res_next.address = addr_reg;
                res_next.port    = port_reg;
                wr_addr        = found_idx_reg;
                wr_data        = found_reg_data;
                state_next     = hkm_pkg::ST_IDLE;
                if (action_reg == hkm_pkg::ACT_REPLY)
                begin
                    if (!found_reg)
                    begin
                        res_next.ev = hkm_pkg::EV_UNKNOWN;
                    end
                    else if (!found_reg_data.waiting)
                    begin
                        res_next.ev = hkm_pkg::EV_REPLY_UNEX;
                        res_next.id = found_reg_data.id;
                    end
                    else
                    begin
                        res_next.ev         = hkm_pkg::EV_REPLY_OK;
                        res_next.id         = found_reg_data.id;
                        res_next.latency    = time_reg - found_reg_data.probe_time;
                        wr_en               = 1'b1;
                        wr_data.last_heard  = time_reg;
                        wr_data.waiting     = 1'b0;
                        wr_data.retries     = 5'd0;
                    end
                end
                else if (action_reg == hkm_pkg::ACT_ADD)
                begin
                    if (found_reg)
                    begin
                        res_next.ev = hkm_pkg::EV_REFUSED;
                    end
                    else if (!free_any)
                    begin
                        res_next.ev   = hkm_pkg::EV_REFUSED;
                        res_next.full = 1'b1;
                    end
                    else
                    begin
                        res_next.ev        = hkm_pkg::EV_ADDED;
                        res_next.id        = next_id_reg;
                        next_id_next       = next_id_reg + 32'd1;
                        valid_next[free_idx] = 1'b1;
                        wr_en              = 1'b1;
                        wr_addr            = free_idx;
                        wr_data.id         = next_id_reg;
                        wr_data.address    = addr_reg;
                        wr_data.port       = port_reg;
                        wr_data.last_heard = time_reg;
                        wr_data.probe_time = time_reg;
                        wr_data.waiting    = 1'b0;
                        wr_data.retries    = 5'd0;
                    end
                end
                else
                begin
                    res_next.address = '0;
                    res_next.port    = '0;
                end
            end

            default:
            begin
                state_next = hkm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hkm_pkg::ST_IDLE;
            time_reg       <= '0;
            next_id_reg    <= '0;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            ev_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            next_id_reg    <= next_id_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            ev_valid_reg   <= ev_valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        addr_reg       <= addr_next;
        port_reg       <= port_next;
        ev_idx_reg     <= ev_idx_next;
        found_idx_reg  <= found_idx_next;
        found_reg_data <= found_data_next;
        pend_reg       <= pend_next;
        res_reg        <= res_next;
    end

    assign busy      = (state_reg != hkm_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/heartbeat_keepalive_monitor.sv */
// ============================================================================
// heartbeat_keepalive_monitor
// Peer liveness table with heartbeat scheduling and timeouts.
// ============================================================================
// Usage:
// An item is taken at a rising edge where start is high and busy is low.
// action selects a tick (advance server time by tick_ms and walk all slots),
// a heartbeat reply, or an add of the peer given by peer_address/peer_port.
// busy stays high from the accepting edge until the final result is shown.
// Each result is shown for one cycle with out_valid high; last marks the
// final result of an item. The receiver cannot stall, so nothing waits.
// A tick reads the slot memory once per slot, as its single read port
// allows, and shows its final result at the end of the walk, with earlier
// results spread over the walk. A reply or add scans the memory until the
// first key match and gives a single result. Another action gives one
// "none" result. busy is already low while the final result is shown, so
// the next item can be taken at the edge that ends it.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata
// while the block is idle, a rule the user must keep, since the block has
// no check of its own for it; an index past the list is ignored.
// Reset clears server time, the id counter and every slot's valid bit,
// and loads the register defaults. No clearing pass is needed.
// ============================================================================
module heartbeat_keepalive_monitor #(
    parameter int MAX_PEERS = hkm_pkg::MAX_PEERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] peer_address,
    input  logic [15:0] peer_port,
    input  logic [15:0] tick_ms,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output logic        out_valid,
    output logic [2:0]  event_res,
    output logic [31:0] peer_id,
    output logic [31:0] out_address,
    output logic [15:0] out_port,
    output logic [31:0] stamp_ms,
    output logic [31:0] latency_ms,
    output logic        refuse_full,
    output logic        last
);

    hkm_pkg::cfg_t    cfg_reg;
    hkm_pkg::result_t res;
    logic             eng_busy;

    // Configuration registers; writes land at once, there is no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval <= hkm_pkg::INTERVAL_RST;
            cfg_reg.retries  <= hkm_pkg::RETRIES_RST;
            cfg_reg.timeout  <= hkm_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hkm_pkg::CFG_INTERVAL: cfg_reg.interval <= cfg_wdata[15:0];
                hkm_pkg::CFG_RETRIES:  cfg_reg.retries  <= cfg_wdata[3:0];
                hkm_pkg::CFG_TIMEOUT:  cfg_reg.timeout  <= cfg_wdata;
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // The engine owns the slot memory and produces every result.
    hkm_engine #(
        .MAX_PEERS (MAX_PEERS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (start && !eng_busy),
        .action       (action),
        .peer_address (peer_address),
        .peer_port    (peer_port),
        .tick_ms      (tick_ms),
        .cfg          (cfg_reg),
        .busy         (eng_busy),
        .res_valid    (out_valid),
        .res          (res)
    );

    assign busy        = eng_busy;
    assign event_res   = res.ev;
    assign peer_id     = res.id;
    assign out_address = res.address;
    assign out_port    = res.port;
    assign stamp_ms    = res.stamp;
    assign latency_ms  = res.latency;
    assign refuse_full = res.full;
    assign last        = res.last;

endmodule

/* rtl/hkm_checker.sv */
// ============================================================================
// hkm_checker
// Port-level checks of the keepalive monitor, bound to the top level.
// ============================================================================
module hkm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        out_valid,
    input logic [2:0]  event_res,
    input logic [31:0] peer_id,
    input logic        last
);

    // An accepted item makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // The final result of an item ends the busy period.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> !busy)
        else $error("final result shown while still busy");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> busy)
        else $error("non-final result shown while idle");

    a_fell_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> out_valid && last)
        else $error("busy dropped without a final result");

    a_refused_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == hkm_pkg::EV_REFUSED
                      || event_res == hkm_pkg::EV_NONE)
        |-> peer_id == hkm_pkg::ALL_ONES)
        else $error("refused or empty result carries a peer id");

endmodule

bind heartbeat_keepalive_monitor hkm_checker u_hkm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .event_res (event_res),
    .peer_id   (peer_id),
    .last      (last)
);

/* bench/heartbeat_keepalive_monitor_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// heartbeat_keepalive_monitor_tb
// Self-checking bench for the peer liveness table. A behavioral copy of the
// table predicts every result of every item; a monitor compares each strobed
// result against the oldest prediction. Directed tests cover the corners,
// then random peer traffic runs under several register settings.
// ============================================================================
module heartbeat_keepalive_monitor_tb;

    import hkm_pkg::*;

    localparam int NPEERS = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [15:0] tick_ms;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        out_valid;
    logic [2:0]  event_res;
    logic [31:0] peer_id;
    logic [31:0] out_address;
    logic [15:0] out_port;
    logic [31:0] stamp_ms;
    logic [31:0] latency_ms;
    logic        refuse_full;
    logic        last;

    heartbeat_keepalive_monitor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .peer_address (peer_address),
        .peer_port    (peer_port),
        .tick_ms      (tick_ms),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .event_res    (event_res),
        .peer_id      (peer_id),
        .out_address  (out_address),
        .out_port     (out_port),
        .stamp_ms     (stamp_ms),
        .latency_ms   (latency_ms),
        .refuse_full  (refuse_full),
        .last         (last)
    );

    // The bench's own picture of the table.
    logic [15:0] mdl_interval;
    logic [3:0]  mdl_max_retries;
    logic [31:0] mdl_timeout;
    logic [31:0] mdl_now;
    logic [31:0] mdl_next_id;
    logic        tbl_valid     [NPEERS];
    logic [31:0] tbl_id        [NPEERS];
    logic [31:0] tbl_addr      [NPEERS];
    logic [15:0] tbl_port      [NPEERS];
    logic [31:0] tbl_heard     [NPEERS];
    logic [31:0] tbl_probe     [NPEERS];
    logic        tbl_waiting   [NPEERS];
    logic [4:0]  tbl_retries   [NPEERS];

    result_t pending_results[$];
    int      error_count;
    int      idle_cycles;
    bit      sender_idling;
    bit      saw_accept;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic result_t make_result(logic [2:0] ev, logic [31:0] id,
                                            logic [31:0] a, logic [15:0] p,
                                            logic [31:0] st, logic [31:0] lat,
                                            logic full);
        result_t r;
        r.ev = ev; r.id = id; r.address = a; r.port = p;
        r.stamp = st; r.latency = lat; r.full = full; r.last = 1'b0;
        return r;
    endfunction

    function automatic int lookup_peer(logic [31:0] a, logic [15:0] p);
        for (int i = 0; i < NPEERS; i++)
            if (tbl_valid[i] && tbl_addr[i] == a && tbl_port[i] == p)
                return i;
        return -1;
    endfunction

    // Updates the table for one item and queues the results it causes.
    task automatic predict_item(logic [1:0] act, logic [31:0] a, logic [15:0] p,
                                logic [15:0] t);
        result_t     produced[$];
        int          s;
        logic [31:0] elapsed;
        logic [47:0] due;
        int          free_slot;
        result_t     r;
        if (act == ACT_TICK)
        begin
            mdl_now = mdl_now + {16'd0, t};
            for (int i = 0; i < NPEERS; i++)
            begin
                if (!tbl_valid[i])
                    continue;
                elapsed = mdl_now - tbl_heard[i];
                if (elapsed < {16'd0, mdl_interval})
                    continue;
                if (elapsed >= mdl_timeout || tbl_retries[i] > {1'b0, mdl_max_retries})
                begin
                    produced.push_back(make_result(EV_TIMEOUT, tbl_id[i], tbl_addr[i],
                                                   tbl_port[i], 0, 0, 1'b0));
                    tbl_valid[i] = 1'b0;
                    continue;
                end
                due = 48'(mdl_interval) * (48'(tbl_retries[i]) + 48'd1);
                if (!tbl_waiting[i] || 48'(elapsed) >= due)
                begin
                    produced.push_back(make_result(EV_SEND, tbl_id[i], tbl_addr[i],
                                                   tbl_port[i], mdl_now, 0, 1'b0));
                    if (tbl_retries[i] == 0)
                        tbl_probe[i] = mdl_now;
                    tbl_waiting[i] = 1'b1;
                    if (tbl_retries[i] != RETRY_SAT)
                        tbl_retries[i] = tbl_retries[i] + 5'd1;
                end
            end
        end
        else if (act == ACT_REPLY)
        begin
            s = lookup_peer(a, p);
            if (s < 0)
                produced.push_back(make_result(EV_UNKNOWN, ALL_ONES, a, p, 0, 0, 1'b0));
            else if (!tbl_waiting[s])
                produced.push_back(make_result(EV_REPLY_UNEX, tbl_id[s], a, p, 0, 0, 1'b0));
            else
            begin
                produced.push_back(make_result(EV_REPLY_OK, tbl_id[s], a, p, 0,
                                               mdl_now - tbl_probe[s], 1'b0));
                tbl_heard[s] = mdl_now;
                tbl_waiting[s] = 1'b0;
                tbl_retries[s] = 5'd0;
            end
        end
        else if (act == ACT_ADD)
        begin
            free_slot = -1;
            for (int i = NPEERS - 1; i >= 0; i--)
                if (!tbl_valid[i])
                    free_slot = i;
            if (lookup_peer(a, p) >= 0)
                produced.push_back(make_result(EV_REFUSED, ALL_ONES, a, p, 0, 0, 1'b0));
            else if (free_slot < 0)
                produced.push_back(make_result(EV_REFUSED, ALL_ONES, a, p, 0, 0, 1'b1));
            else
            begin
                tbl_valid[free_slot] = 1'b1;
                tbl_id[free_slot] = mdl_next_id;
                tbl_addr[free_slot] = a;
                tbl_port[free_slot] = p;
                tbl_heard[free_slot] = mdl_now;
                tbl_probe[free_slot] = mdl_now;
                tbl_waiting[free_slot] = 1'b0;
                tbl_retries[free_slot] = 5'd0;
                produced.push_back(make_result(EV_ADDED, mdl_next_id, a, p, 0, 0, 1'b0));
                mdl_next_id = mdl_next_id + 32'd1;
            end
        end
        // A tick with nothing to report, or the unused action code, still
        // gives one empty result so that every item ends with last set.
        if (produced.size() == 0)
            produced.push_back(make_result(EV_NONE, ALL_ONES, 0, 0, 0, 0, 1'b0));
        produced[produced.size() - 1].last = 1'b1;
        foreach (produced[k])
            pending_results.push_back(produced[k]);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("[%0t] MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing expected, event",
                                32'(event_res), 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (event_res !== want.ev)
                    report_mismatch("event", 32'(event_res), 32'(want.ev));
                if (peer_id !== want.id)        report_mismatch("peer_id", peer_id, want.id);
                if (out_address !== want.address)
                    report_mismatch("address", out_address, want.address);
                if (out_port !== want.port)
                    report_mismatch("port", 32'(out_port), 32'(want.port));
                if (stamp_ms !== want.stamp)    report_mismatch("stamp", stamp_ms, want.stamp);
                if (latency_ms !== want.latency)
                    report_mismatch("latency", latency_ms, want.latency);
                if (refuse_full !== want.full)
                    report_mismatch("refuse_full", 32'(refuse_full), 32'(want.full));
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        end
    end

    // The watchdog counts cycles with neither an accepted item nor a result.
    always @(posedge clk)
    begin
        if (!rst_n || out_valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("heartbeat_keepalive_monitor verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Sends one item; start stays high until the accepting edge, then the
    // prediction is made for exactly the item the block took. The block is
    // busy for the cycle after that edge, so waiting it out costs nothing.
    task automatic send_item(logic [1:0] act, logic [31:0] a, logic [15:0] p,
                             logic [15:0] t);
        int gap;
        if (sender_idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        peer_address <= a;
        peer_port <= p;
        tick_ms <= t;
        do
            @(posedge clk);
        while (busy);
        predict_item(act, a, p, t);
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted result has arrived and the block is idle.
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_INTERVAL: mdl_interval = value[15:0];
            CFG_RETRIES:  mdl_max_retries = value[3:0];
            CFG_TIMEOUT:  mdl_timeout = value;
            default: ;
        endcase
    endtask

    task automatic set_registers(logic [15:0] iv, logic [3:0] mr, logic [31:0] to);
        write_register(CFG_INTERVAL, {16'd0, iv});
        write_register(CFG_RETRIES, {28'd0, mr});
        write_register(CFG_TIMEOUT, to);
    endtask

    // A small pool of keys so that replies and duplicates hit often.
    function automatic logic [31:0] pool_address(int k);
        return 32'hC0A8_0000 | 32'(k * 7);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_defaults_and_corners();
        // Empty tick, unused action code, unknown peer, extreme field values.
        send_item(ACT_TICK, 0, 0, 16'd0);
        send_item(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_item(ACT_REPLY, 32'hFFFF_FFFF, 16'hFFFF, 0);
        send_item(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, 0);
        send_item(ACT_ADD, 32'h0000_0000, 16'h0000, 0);
        // A duplicate, and a reply from a peer that was never probed.
        send_item(ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, 0);
        send_item(ACT_REPLY, 32'h0000_0000, 16'h0000, 0);
        // Probe, answer with latency, then let long ticks time the peers out.
        send_item(ACT_TICK, 0, 0, 16'd1000);
        send_item(ACT_TICK, 0, 0, 16'd300);
        send_item(ACT_REPLY, 32'hFFFF_FFFF, 16'hFFFF, 0);
        for (int i = 0; i < 8; i++)
            send_item(ACT_TICK, 0, 0, 16'hFFFF);
    endtask

    task automatic test_full_table();
        // Fill all slots, then refuse a new key as full and an old one as a
        // duplicate even though the table is full.
        for (int k = 0; k < NPEERS; k++)
            send_item(ACT_ADD, pool_address(k), 16'(k), 0);
        send_item(ACT_ADD, 32'h1234_5678, 16'h4321, 0);
        send_item(ACT_ADD, pool_address(3), 16'd3, 0);
        // A slot freed by a timeout is taken again by the next add.
        send_item(ACT_TICK, 0, 0, 16'hFFFF);
        send_item(ACT_ADD, 32'h1234_5678, 16'h4321, 0);
    endtask

    // Long ticks under the widest register settings.
    task automatic test_time_wrap();
        set_registers(16'hFFFF, 4'd15, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_item(ACT_TICK, 0, 0, 16'hFFFF);
        send_item(ACT_ADD, 32'hA5A5_5A5A, 16'h8001, 0);
        send_item(ACT_TICK, 0, 0, 16'hFFFF);
        send_item(ACT_REPLY, 32'hA5A5_5A5A, 16'h8001, 0);
    endtask

    task automatic run_random(int count, bit with_idling);
        int          k;
        int          choice;
        logic [31:0] a;
        logic [15:0] p;
        sender_idling = with_idling;
        for (int n = 0; n < count; n++)
        begin
            choice = $urandom_range(0, 99);
            k = $urandom_range(0, 19);
            if (choice < 5)
            begin
                a = $urandom();
                p = $urandom();
            end
            else
            begin
                a = pool_address(k);
                p = 16'(k);
            end
            if (choice < 40)
                send_item(ACT_TICK, 0, 0, ($urandom_range(0, 9) == 0) ?
                          16'($urandom()) : 16'(($urandom_range(0, 3) * mdl_interval) / 2));
            else if (choice < 70)
                send_item(ACT_REPLY, a, p, 16'($urandom()));
            else if (choice < 97)
                send_item(ACT_ADD, a, p, 16'($urandom()));
            else
                send_item(2'd3, a, p, 16'($urandom()));
        end
        sender_idling = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_TICK;
        peer_address = '0;
        peer_port = '0;
        tick_ms = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_INTERVAL;
        cfg_wdata = '0;
        error_count = 0;
        sender_idling = 1'b0;
        mdl_interval = INTERVAL_RST;
        mdl_max_retries = RETRIES_RST;
        mdl_timeout = TIMEOUT_RST;
        mdl_now = 0;
        mdl_next_id = 0;
        for (int i = 0; i < NPEERS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_waiting[i] = 1'b0;
            tbl_retries[i] = 5'd0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_and_corners();
        test_full_table();
        test_time_wrap();

        // Random traffic under several settings, the extremes among them.
        set_registers(16'd1, 4'd0, 32'd1);
        run_random(30, 1'b1);
        set_registers(16'd100, 4'd3, 32'd2000);
        run_random(40, 1'b1);
        // The sender holds off here until the block has caught up.
        drain_results();
        set_registers(16'd1000, 4'd15, 32'hFFFF_FFFF);
        run_random(40, 1'b1);
        set_registers(16'd500, 4'd2, 32'd20000);
        run_random(65, 1'b0);

        drain_results();
        repeat (40) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("heartbeat_keepalive_monitor verification clean");
        else
            $display("heartbeat_keepalive_monitor verification failed");
        $finish;
    end

endmodule
